>>> rtl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

   localparam int ByteWidth = 8;
   localparam int LenWidth  = 64;
   localparam int KeyWidth  = 32;

   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_CLOSE = 2'd1,
      KIND_PING  = 2'd2,
      KIND_PONG  = 2'd3
   } kind_type;

   typedef struct packed {
      logic                 valid;
      kind_type             kind;
      logic [ByteWidth-1:0] data;
      logic                 last;
      logic                 fin;
   } result_type;

endpackage

>>> rtl/wsfd_parser.sv
// Header parser, length/key tracking and payload unmasking for one byte.
module wsfd_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [wsfd_pkg::ByteWidth-1:0]  byte_in,
   output wsfd_pkg::result_type            result
);

   wsfd_pkg::phase_type               phase_ff, phase_in;
   logic [3:0]                        opcode_ff, opcode_in;
   logic                              fin_ff, fin_in;
   logic                              mask_ff, mask_in;
   logic [3:0]                        hdr_left_ff, hdr_left_in;
   logic [wsfd_pkg::LenWidth-1:0]     remaining_ff, remaining_in;
   logic [wsfd_pkg::KeyWidth-1:0]     key_ff, key_in;
   logic [1:0]                        key_idx_ff, key_idx_in;

   logic                              is_control;
   logic [wsfd_pkg::ByteWidth-1:0]    key_byte;
   logic [wsfd_pkg::LenWidth-1:0]     remaining_dec;
   logic [3:0]                        hdr_left_dec;
   logic [6:0]                        len7;
   logic [3:0]                        op_new;
   logic                              op_new_control;

   assign is_control = (opcode_ff == wsfd_pkg::OP_CLOSE) || (opcode_ff == wsfd_pkg::OP_PING) ||
                       (opcode_ff == wsfd_pkg::OP_PONG);
   assign op_new = byte_in[3:0];
   assign op_new_control = (op_new == wsfd_pkg::OP_CLOSE) || (op_new == wsfd_pkg::OP_PING) ||
                           (op_new == wsfd_pkg::OP_PONG);
   assign remaining_dec = remaining_ff - {{(wsfd_pkg::LenWidth-1){1'b0}}, 1'b1};
   assign hdr_left_dec  = hdr_left_ff - 4'd1;
   assign len7          = byte_in[6:0];

   always_comb begin
      case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         2'd3:    key_byte = key_ff[7:0];
         default: key_byte = key_ff[31:24];
      endcase
   end

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      opcode_in    = opcode_ff;
      fin_in       = fin_ff;
      mask_in      = mask_ff;
      hdr_left_in  = hdr_left_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      key_idx_in   = key_idx_ff;
      case (phase_ff)
         wsfd_pkg::PH_HDR1: begin
            mask_in = byte_in[7];
            if (len7 == wsfd_pkg::LEN7_EXT16) begin
               remaining_in = '0;
               hdr_left_in  = wsfd_pkg::EXT16_BYTES;
               phase_in     = wsfd_pkg::PH_EXTLEN;
            end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
               remaining_in = '0;
               hdr_left_in  = wsfd_pkg::EXT64_BYTES;
               phase_in     = wsfd_pkg::PH_EXTLEN;
            end else begin
               remaining_in = {{(wsfd_pkg::LenWidth-7){1'b0}}, len7};
               if (byte_in[7]) begin
                  hdr_left_in = wsfd_pkg::KEY_BYTES;
                  phase_in    = wsfd_pkg::PH_KEY;
               end else if (len7 == 7'd0) begin
                  phase_in = wsfd_pkg::PH_HDR0;
               end else begin
                  phase_in = wsfd_pkg::PH_PAYLOAD;
               end
            end
         end
         wsfd_pkg::PH_EXTLEN: begin
            // shift in big-endian length bytes
            remaining_in = {remaining_ff[wsfd_pkg::LenWidth-9:0], byte_in};
            hdr_left_in  = hdr_left_dec;
            if (hdr_left_dec == 4'd0) begin
               if (mask_ff) begin
                  hdr_left_in = wsfd_pkg::KEY_BYTES;
                  phase_in    = wsfd_pkg::PH_KEY;
               end else if (remaining_in == '0) begin
                  phase_in = wsfd_pkg::PH_HDR0;
               end else begin
                  phase_in = wsfd_pkg::PH_PAYLOAD;
               end
            end
         end
         wsfd_pkg::PH_KEY: begin
            key_in      = {key_ff[wsfd_pkg::KeyWidth-9:0], byte_in};
            hdr_left_in = hdr_left_dec;
            if (hdr_left_dec == 4'd0) begin
               phase_in = (remaining_ff == '0) ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
            end
         end
         wsfd_pkg::PH_PAYLOAD: begin
            if (mask_ff) begin
               key_idx_in = key_idx_ff + 2'd1;
            end
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in = wsfd_pkg::PH_HDR0;
            end
         end
         default: begin
            fin_in       = byte_in[7];
            opcode_in    = op_new;
            mask_in      = 1'b0;
            key_in       = '0;
            key_idx_in   = 2'd0;
            hdr_left_in  = 4'd0;
            remaining_in = '0;
            phase_in     = wsfd_pkg::PH_HDR1;
         end
      endcase
   end

   // Result
   always_comb begin
      result       = '0;
      result.kind  = wsfd_pkg::KIND_DATA;
      case (phase_ff)
         wsfd_pkg::PH_HDR1, wsfd_pkg::PH_EXTLEN, wsfd_pkg::PH_KEY: begin
            result.valid = 1'b0;
         end
         wsfd_pkg::PH_PAYLOAD: begin
            result.valid = !is_control;
            result.data  = byte_in ^ (mask_ff ? key_byte : '0);
            result.last  = (remaining_dec == '0);
            result.fin   = fin_ff;
         end
         default: begin
            result.valid = op_new_control;
            result.fin   = byte_in[7];
            if (op_new == wsfd_pkg::OP_CLOSE) begin
               result.kind = wsfd_pkg::KIND_CLOSE;
            end else if (op_new == wsfd_pkg::OP_PING) begin
               result.kind = wsfd_pkg::KIND_PING;
            end else begin
               result.kind = wsfd_pkg::KIND_PONG;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wsfd_pkg::PH_HDR0;
         opcode_ff    <= 4'd0;
         fin_ff       <= 1'b0;
         mask_ff      <= 1'b0;
         hdr_left_ff  <= 4'd0;
         remaining_ff <= '0;
         key_ff       <= '0;
         key_idx_ff   <= 2'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         opcode_ff    <= opcode_in;
         fin_ff       <= fin_in;
         mask_ff      <= mask_in;
         hdr_left_ff  <= hdr_left_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         key_idx_ff   <= key_idx_in;
      end
   end

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsfd_pkg::PH_PAYLOAD |-> remaining_ff != '0)
      else $error("payload phase with zero bytes remaining");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsfd_pkg::PH_EXTLEN || phase_ff == wsfd_pkg::PH_KEY) |-> hdr_left_ff != 4'd0)
      else $error("extended header phase with no bytes left");

   a_event_clean: assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.kind != wsfd_pkg::KIND_DATA) |->
         (result.data == '0 && !result.last && phase_ff == wsfd_pkg::PH_HDR0))
      else $error("event result outside first header byte or with payload marks");

   a_key_idx_unmasked: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsfd_pkg::PH_PAYLOAD && !mask_ff) |-> key_idx_ff == 2'd0)
      else $error("key index moved in an unmasked frame");

endmodule

>>> rtl/wsfd_out_reg.sv
// Result register driving the master-side stream.
module wsfd_out_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  wsfd_pkg::result_type           result,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [wsfd_pkg::ByteWidth-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   output logic [2:0]                     rsp_tuser,
   output logic                           can_load
);

   logic                 valid_ff, valid_in;
   wsfd_pkg::result_type data_ff;

   assign can_load = !valid_ff || rsp_tready;

   // drop the held result once taken, replace it when a new byte is processed
   always_comb begin
      if (can_load) begin
         valid_in = load && result.valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_load && load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.data;
   assign rsp_tlast  = data_ff.last;
   assign rsp_tuser  = {data_ff.fin, data_ff.kind};

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |=> (valid_ff && $stable(data_ff)))
      else $error("held result changed while stalled");

   a_no_load_when_blocked: assert property (@(posedge clock) disable iff (reset)
      load |-> can_load)
      else $error("byte processed while result register blocked");

   a_data_result_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff.kind != wsfd_pkg::KIND_DATA) |-> !data_ff.last)
      else $error("event result carries last mark");

endmodule

>>> rtl/websocket_frame_deframer.sv
// Path: input register, parser, result register, rsp_. Throughput: one byte per cycle
//   unless rsp_ stalls; input register, parser and result register advance together,
//   so a stall on rsp_ holds at most one byte in the input register.
// Reset (synchronous, active high): parser returns to the first header byte with
//   length, key and flags cleared; both stream registers empty.
// Top level: WebSocket frame deframer, byte in, unmasked payload or event out.
module websocket_frame_deframer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [wsfd_pkg::ByteWidth-1:0] req_tdata,   // [7:0] in_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [wsfd_pkg::ByteWidth-1:0] rsp_tdata,   // [7:0] out_byte
   output logic                           rsp_tlast,   // out_last
   output logic [2:0]                     rsp_tuser    // [1:0] out_kind, [2] out_final
);

   logic                           in_valid_ff, in_valid_in;
   logic [wsfd_pkg::ByteWidth-1:0] in_byte_ff;
   logic                           can_load;
   logic                           advance;
   wsfd_pkg::result_type           result;

   assign advance    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   wsfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (in_byte_ff),
      .result  (result)
   );

   wsfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .can_load   (can_load)
   );

   a_hold_blocked_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !can_load) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("pending byte lost while result register blocked");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input not ready while input register empty");

   a_advance_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && !req_tvalid) |=> !in_valid_ff)
      else $error("processed byte stayed in input register");

endmodule
